/* rtl/oahm_pkg.sv */
// Shared types and constants for the open-addressing hash map.
// No dependencies.
package oahm_pkg;
  localparam int TABLE_DEPTH = 4096;
  localparam int START_SIZE  = 8;
  localparam int KEY_BYTES   = 8;
  localparam int VALUE_BITS  = 32;
  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int ADDR_W = IDX_W + 1;
  localparam int SIZE_W = IDX_W + 1;
  localparam int CNT_W  = 13;
  localparam int QDEPTH = 2;

  localparam logic [2:0] OP_GET    = 3'd0;
  localparam logic [2:0] OP_SET    = 3'd1;
  localparam logic [2:0] OP_ADD    = 3'd2;
  localparam logic [2:0] OP_REMOVE = 3'd3;
  localparam logic [2:0] OP_HAS    = 3'd4;
  localparam logic [2:0] OP_CLEAR  = 3'd5;

  localparam logic [1:0] MARK_EMPTY = 2'd0;
  localparam logic [1:0] MARK_LIVE  = 2'd1;
  localparam logic [1:0] MARK_TOMB  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_MISS  = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]            op;
    logic                  bad_op;
    logic [63:0]           key;
    logic [3:0]            len;
    logic [31:0]           hash;
    logic [VALUE_BITS-1:0] value;
    logic [VALUE_BITS-1:0] dflt;
  } cmd_t;
endpackage

/* rtl/oahm_front.sv */
// Front end: normalizes the key and hashes it one byte per cycle.
// Depends on oahm_pkg.
module oahm_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_take,
  input  logic [2:0]                     in_op,
  input  logic [63:0]                    in_key,
  input  logic [3:0]                     in_key_len,
  input  logic [oahm_pkg::VALUE_BITS-1:0] in_value,
  input  logic [oahm_pkg::VALUE_BITS-1:0] in_default_value,
  output logic                           busy,
  output logic                           cmd_valid,
  output oahm_pkg::cmd_t                 cmd,
  input  logic                           cmd_ready
);
  import oahm_pkg::*;

  cmd_t       cmd_r;
  logic       run_r, done_r;
  logic [3:0] b_r;
  logic [3:0] len_c;
  logic [63:0] mask_c;

  always_comb begin
    len_c = in_key_len;
    if (len_c == 4'd0) len_c = 4'd1;
    if (len_c > 4'(KEY_BYTES)) len_c = 4'(KEY_BYTES);
    mask_c = '0;
    for (int k = 0; k < 8; k++)
      if (k < int'(len_c)) mask_c[k*8 +: 8] = 8'hff;
  end

  assign busy      = run_r | done_r;
  assign cmd_valid = done_r;
  assign cmd       = cmd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else if (in_take) begin
      cmd_r.op     <= in_op;
      cmd_r.bad_op <= (in_op > OP_CLEAR);
      cmd_r.key    <= in_key & mask_c;
      cmd_r.len    <= len_c;
      cmd_r.hash   <= '0;
      cmd_r.value  <= in_value;
      cmd_r.dflt   <= in_default_value;
      b_r          <= '0;
      run_r        <= 1'b1;
    end else if (run_r) begin
      // h = h*131 + byte
      cmd_r.hash <= (cmd_r.hash << 7) + (cmd_r.hash << 1) + cmd_r.hash
                    + 32'(cmd_r.key[b_r[2:0]*8 +: 8]);
      b_r <= b_r + 4'd1;
      if (b_r + 4'd1 == cmd_r.len) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end else if (done_r && cmd_ready) begin
      done_r <= 1'b0;
    end
  end
endmodule

/* rtl/oahm_queue.sv */
// Two-entry command queue between front and back end.
// Depends on oahm_pkg.
module oahm_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  oahm_pkg::cmd_t push_cmd,
  output logic           full,
  output logic           not_empty,
  output oahm_pkg::cmd_t head,
  input  logic           pop
);
  import oahm_pkg::*;

  cmd_t       mem_r [QDEPTH];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full      = (cnt_r == 2'(QDEPTH));
  assign not_empty = (cnt_r != 2'd0);
  assign head      = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_cmd;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule

/* rtl/oahm_back.sv */
// Back end: probe sequencer over the slot memories, updates, clear and
// rehash sweeps. Depends on oahm_pkg.
module oahm_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cmd_valid,
  input  oahm_pkg::cmd_t                  cmd,
  output logic                            cmd_pop,
  output logic                            out_valid,
  output logic [1:0]                      out_status,
  output logic                            out_found,
  output logic [oahm_pkg::VALUE_BITS-1:0] out_result_value
);
  import oahm_pkg::*;

  typedef enum logic [9:0] {
    S_INIT  = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_RD    = 10'b0000000100,
    S_CHK   = 10'b0000001000,
    S_ACT   = 10'b0000010000,
    S_GCLR  = 10'b0000100000,
    S_GRD   = 10'b0001000000,
    S_GCHK  = 10'b0010000000,
    S_GPRB  = 10'b0100000000,
    S_CLR   = 10'b1000000000
  } st_t;

  localparam int DEPTH = 2 * TABLE_DEPTH;

  // slot memories: single write port, single registered read port
  logic [63:0]           keys_m [DEPTH];
  logic [3:0]            lens_m [DEPTH];
  logic [31:0]           hash_m [DEPTH];
  logic [VALUE_BITS-1:0] vals_m [DEPTH];
  logic [1:0]            mark_m [DEPTH];

  logic [ADDR_W-1:0]     raddr, waddr;
  logic                  we_mark, we_data, we_val;
  logic [1:0]            wmark;
  logic [63:0]           wkey, rkey;
  logic [3:0]            wlen, rlen;
  logic [31:0]           whash, rhash;
  logic [VALUE_BITS-1:0] wval, rval;
  logic [1:0]            rmark;

  always_ff @(posedge clk) begin
    if (we_mark) mark_m[waddr] <= wmark;
    if (we_data) begin
      keys_m[waddr] <= wkey;
      lens_m[waddr] <= wlen;
      hash_m[waddr] <= whash;
    end
    if (we_val) vals_m[waddr] <= wval;
    rmark <= mark_m[raddr];
    rkey  <= keys_m[raddr];
    rlen  <= lens_m[raddr];
    rhash <= hash_m[raddr];
    rval  <= vals_m[raddr];
  end

  st_t                   st_r, st_nxt;
  logic                  bank_r;
  logic [SIZE_W-1:0]     size_r, nsize_r;
  logic [CNT_W-1:0]      live_r, filled_r, gcnt_r;
  logic [31:0]           i_r, p_r;
  logic [IDX_W-1:0]      slot_r, tomb_r;
  logic                  have_tomb_r;
  logic [IDX_W:0]        sweep_r, j_r;
  logic [IDX_W+2:0]      n_r;
  cmd_t                  c_r;
  logic [IDX_W-1:0]      mask_c, nmask_c;
  logic [31:0]           inext_c;
  logic                  hit_c;

  // result of the probe, latched in S_CHK
  logic                  hit_act_r, ok_r;
  logic [VALUE_BITS-1:0] hval_r;
  logic                  is_ins, ins_c, grow_c, full_c;
  logic [IDX_W-1:0]      ins_slot_c;
  logic [CNT_W-1:0]      filled_new;

  assign mask_c  = IDX_W'(size_r - 1'b1);
  assign nmask_c = IDX_W'(nsize_r - 1'b1);
  assign inext_c = (i_r << 2) + i_r + p_r + 32'd1;
  assign hit_c   = rmark == MARK_LIVE && rlen == c_r.len && rhash == c_r.hash
                   && rkey == c_r.key;

  // Next grow size: smallest pow2 from 8 above 4*size, capped.
  function automatic logic [SIZE_W-1:0] grow_size(logic [SIZE_W-1:0] sz,
                                                  logic [CNT_W-1:0] live);
    logic [SIZE_W+2:0] want;
    logic [SIZE_W+2:0] ns;
    want = (live > CNT_W'(50000 % (1 << CNT_W)) && 50000 < (1 << CNT_W)) ?
           (SIZE_W+3)'(sz) << 1 : (SIZE_W+3)'(sz) << 2;
    ns = (want << 1) & ~want;
    for (int k = 0; k < SIZE_W + 3; k++)
      if (want[k]) ns = (SIZE_W+3)'(1) << (k + 1);
    if (ns < (SIZE_W+3)'(8)) ns = (SIZE_W+3)'(8);
    if (ns > (SIZE_W+3)'(TABLE_DEPTH)) ns = (SIZE_W+3)'(TABLE_DEPTH);
    return SIZE_W'(ns);
  endfunction

  always_comb begin
    st_nxt  = st_r;
    raddr   = {bank_r, IDX_W'(c_r.hash) & mask_c};
    waddr   = {bank_r, slot_r};
    we_mark = 1'b0;
    we_data = 1'b0;
    we_val  = 1'b0;
    wmark   = MARK_LIVE;
    wkey    = c_r.key;
    wlen    = c_r.len;
    whash   = c_r.hash;
    wval    = c_r.value;
    cmd_pop = 1'b0;
    case (st_r)
      S_INIT: begin
        waddr   = ADDR_W'(sweep_r);
        wmark   = MARK_EMPTY;
        we_mark = 1'b1;
        if (sweep_r[IDX_W]) st_nxt = S_IDLE;
      end
      S_IDLE: if (cmd_valid) begin
        cmd_pop = 1'b1;
        st_nxt  = S_RD;
      end
      S_RD: begin
        if (c_r.bad_op) st_nxt = S_IDLE;
        else if (c_r.op == OP_CLEAR) st_nxt = S_CLR;
        else st_nxt = S_CHK;
        raddr = {bank_r, IDX_W'(c_r.hash) & mask_c};
      end
      S_CHK: begin
        raddr = {bank_r, IDX_W'(inext_c) & mask_c};
        if (rmark == MARK_EMPTY || hit_c || n_r >= (IDX_W+3)'({size_r, 1'b0} + 16))
          st_nxt = S_ACT;
      end
      S_ACT: begin
        st_nxt = S_IDLE;
      end
      S_CLR: begin
        waddr   = {bank_r, IDX_W'(sweep_r)};
        wmark   = MARK_EMPTY;
        we_mark = 1'b1;
        if (sweep_r + 1'b1 == (IDX_W+1)'(size_r)) st_nxt = S_IDLE;
      end
      S_GCLR: begin
        waddr   = {~bank_r, IDX_W'(sweep_r)};
        wmark   = MARK_EMPTY;
        we_mark = 1'b1;
        raddr   = {bank_r, IDX_W'(j_r)};
        if (sweep_r + 1'b1 == (IDX_W+1)'(nsize_r)) st_nxt = S_GRD;
      end
      S_GRD: begin
        raddr  = {bank_r, IDX_W'(j_r)};
        st_nxt = S_GCHK;
      end
      S_GCHK: begin
        // old slot data now in read regs; look up first target
        raddr = {~bank_r, IDX_W'(rhash) & nmask_c};
        if (rmark == MARK_LIVE) st_nxt = S_GPRB;
        else if (j_r + 1'b1 == (IDX_W+1)'(size_r)) st_nxt = S_IDLE;
        else st_nxt = S_GRD;
      end
      S_GPRB: begin
        raddr = {~bank_r, IDX_W'(inext_c) & nmask_c};
        if (rmark == MARK_EMPTY) begin
          waddr   = {~bank_r, IDX_W'(i_r) & nmask_c};
          wkey    = c_r.key;
          wlen    = c_r.len;
          whash   = c_r.hash;
          wval    = c_r.value;
          we_mark = 1'b1;
          we_data = 1'b1;
          we_val  = 1'b1;
          if (j_r + 1'b1 == (IDX_W+1)'(size_r)) st_nxt = S_IDLE;
          else st_nxt = S_GRD;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
    if (st_r == S_ACT && !c_r.bad_op) begin
      if (hit_act_r && c_r.op == OP_SET) begin
        waddr  = {bank_r, slot_r};
        we_val = 1'b1;
      end else if (hit_act_r && c_r.op == OP_REMOVE) begin
        waddr   = {bank_r, slot_r};
        wmark   = MARK_TOMB;
        we_mark = 1'b1;
      end else if (ins_c) begin
        waddr   = {bank_r, ins_slot_c};
        we_mark = 1'b1;
        we_data = 1'b1;
        we_val  = 1'b1;
      end
      if (ins_c && grow_c) st_nxt = S_GCLR;
    end
  end

  always_comb begin
    is_ins     = (c_r.op == OP_SET || c_r.op == OP_ADD);
    ins_slot_c = (have_tomb_r) ? tomb_r : slot_r;
    full_c     = is_ins && !hit_act_r && (!ok_r ||
                 (!have_tomb_r && (filled_r + 1'b1 >= CNT_W'(size_r))));
    ins_c      = is_ins && !hit_act_r && !full_c;
    filled_new = filled_r + CNT_W'(!have_tomb_r);
    grow_c     = ((CNT_W+2)'(filled_new) * 3 >= (CNT_W+2)'(size_r) * 2) &&
                 (grow_size(size_r, live_r + 1'b1) > size_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
      st_r    <= S_INIT;
      sweep_r <= '0;
      bank_r  <= 1'b0;
      size_r  <= SIZE_W'(START_SIZE);
      live_r  <= '0;
      filled_r <= '0;
    end else begin
      out_valid <= (st_r == S_RD && c_r.bad_op) || st_r == S_ACT ||
                   (st_r == S_CLR && st_nxt == S_IDLE);
      st_r <= st_nxt;
      case (st_r)
        S_INIT: sweep_r <= sweep_r + 1'b1;
        S_IDLE: if (cmd_valid) c_r <= cmd;
        S_RD: begin
          i_r         <= c_r.hash;
          p_r         <= c_r.hash;
          n_r         <= '0;
          have_tomb_r <= 1'b0;
          sweep_r     <= '0;
          slot_r      <= IDX_W'(c_r.hash) & mask_c;
          if (c_r.bad_op) begin
            out_status       <= ST_OK;
            out_found        <= 1'b0;
            out_result_value <= '0;
          end
        end
        S_CHK: begin
          hit_act_r <= hit_c;
          hval_r    <= rval;
          // probe bound reached without a hit or an empty slot
          ok_r      <= !(st_nxt == S_ACT && rmark != MARK_EMPTY && !hit_c) ||
                       have_tomb_r || rmark == MARK_TOMB;
          if (rmark == MARK_TOMB && !have_tomb_r) begin
            have_tomb_r <= 1'b1;
            tomb_r      <= slot_r;
          end
          i_r    <= inext_c;
          p_r    <= p_r >> 5;
          n_r    <= n_r + 1'b1;
          if (st_nxt != S_ACT) slot_r <= IDX_W'(inext_c) & mask_c;
        end
        S_ACT: begin
          out_found        <= hit_act_r;
          out_result_value <= (c_r.op == OP_GET) ? (hit_act_r ? hval_r : c_r.dflt) : '0;
          if (c_r.op == OP_GET || c_r.op == OP_REMOVE || c_r.op == OP_HAS)
            out_status <= hit_act_r ? ST_OK : ST_MISS;
          else out_status <= full_c ? ST_FULL : ST_OK;
          if (hit_act_r && c_r.op == OP_REMOVE) live_r <= live_r - 1'b1;
          if (ins_c) begin
            live_r   <= live_r + 1'b1;
            filled_r <= filled_new;
            if (grow_c) begin
              nsize_r <= grow_size(size_r, live_r + 1'b1);
              sweep_r <= '0;
              j_r     <= '0;
              gcnt_r  <= '0;
            end
          end
        end
        S_CLR: begin
          sweep_r <= sweep_r + 1'b1;
          if (st_nxt == S_IDLE) begin
            live_r   <= '0;
            filled_r <= '0;
            out_status       <= ST_OK;
            out_found        <= 1'b0;
            out_result_value <= '0;
          end
        end
        S_GCLR: sweep_r <= sweep_r + 1'b1;
        S_GCHK: begin
          // stash old entry in the command register while it is rehashed
          c_r.key   <= rkey;
          c_r.len   <= rlen;
          c_r.hash  <= rhash;
          c_r.value <= rval;
          i_r       <= rhash;
          p_r       <= rhash;
          if (rmark != MARK_LIVE) j_r <= j_r + 1'b1;
          if (rmark != MARK_LIVE && st_nxt == S_IDLE) begin
            bank_r   <= ~bank_r;
            size_r   <= nsize_r;
            live_r   <= gcnt_r;
            filled_r <= gcnt_r;
          end
        end
        S_GPRB: begin
          if (rmark == MARK_EMPTY) begin
            j_r    <= j_r + 1'b1;
            gcnt_r <= gcnt_r + 1'b1;
            if (st_nxt == S_IDLE) begin
              bank_r   <= ~bank_r;
              size_r   <= nsize_r;
              live_r   <= gcnt_r + 1'b1;
              filled_r <= gcnt_r + 1'b1;
            end
          end else begin
            i_r <= inext_c;
            p_r <= p_r >> 5;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

/* rtl/open_addressing_hash_map_top.sv */
// Top level of the open-addressing hash map: front, queue and back end.
// Depends on oahm_pkg, oahm_front, oahm_queue, oahm_back.
//
//  channel  handshake               payload
//  in_      start & !busy           in_op in_key in_key_len in_value in_default_value
//  out_     out_valid (one cycle)   out_status out_found out_result_value
//
// The front hashes the key one byte at a time, then hands the item to the
// queue; the back end reads the home slot, checks one probed slot at a
// time, then acts and registers the result.
// A grow clears the new bank's marks, then reads each old slot and
// reprobes each live one into the new bank. After reset the back end
// clears the marks of the first bank.
// Results cannot be held off; busy is high while the front hashes an item
// and until the queue takes that item.
module open_addressing_hash_map_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [2:0]                      in_op,
  input  logic [63:0]                     in_key,
  input  logic [3:0]                      in_key_len,
  input  logic [oahm_pkg::VALUE_BITS-1:0] in_value,
  input  logic [oahm_pkg::VALUE_BITS-1:0] in_default_value,
  output logic                            out_valid,
  output logic [1:0]                      out_status,
  output logic                            out_found,
  output logic [oahm_pkg::VALUE_BITS-1:0] out_result_value
);
  import oahm_pkg::*;

  logic fbusy, fvalid, qfull, qne, pop, push;
  cmd_t fcmd, qhead;

  assign busy = fbusy;
  assign push = fvalid && !qfull;

  oahm_front u_front (
    .clk, .rst_n, .in_take(start && !fbusy), .in_op, .in_key, .in_key_len,
    .in_value, .in_default_value, .busy(fbusy), .cmd_valid(fvalid), .cmd(fcmd),
    .cmd_ready(!qfull)
  );

  oahm_queue u_queue (
    .clk, .rst_n, .push, .push_cmd(fcmd), .full(qfull), .not_empty(qne),
    .head(qhead), .pop
  );

  oahm_back u_back (
    .clk, .rst_n, .cmd_valid(qne), .cmd(qhead), .cmd_pop(pop), .out_valid,
    .out_status, .out_found, .out_result_value
  );
endmodule

/* test/open_addressing_hash_map_top_tb.sv */
// Self-checking testbench for open_addressing_hash_map_top.
// Depends on oahm_pkg and the RTL of the hash map; a class-based scoreboard
// mirrors the table (probing, tombstones, growth) and checks every result.
`timescale 1ns / 1ps

module open_addressing_hash_map_top_tb;
  import oahm_pkg::*;

  localparam logic [2:0] OP_RSVD_A = 3'd6;
  localparam logic [2:0] OP_RSVD_B = 3'd7;
  localparam int STORE_DEPTH  = 2 * TABLE_DEPTH;
  localparam int BIG_TABLE    = 50000;
  localparam int IDLE_LIMIT   = 60000;
  localparam int N_RANDOM     = 1430;
  localparam int POOL_MAX     = 800;

  typedef struct {
    logic [1:0]            status;
    logic                  found;
    logic [VALUE_BITS-1:0] value;
  } map_answer_t;

  class hash_scoreboard;
    bit [63:0]           slot_key   [STORE_DEPTH];
    bit [3:0]            slot_len   [STORE_DEPTH];
    bit [31:0]           slot_hash  [STORE_DEPTH];
    bit [VALUE_BITS-1:0] slot_val   [STORE_DEPTH];
    bit [1:0]            slot_mark  [STORE_DEPTH];
    int unsigned bank, size, live, filled;
    int errors;
    map_answer_t answers[$];

    function new();
      bank = 0;
      size = START_SIZE;
      live = 0;
      filled = 0;
      errors = 0;
      foreach (slot_mark[j]) slot_mark[j] = MARK_EMPTY;
    endfunction

    function bit [31:0] bkdr(bit [63:0] k, int unsigned n);
      bit [31:0] h;
      h = 0;
      for (int b = 0; b < n; b++) h = h * 32'd131 + {24'd0, k[8*b +: 8]};
      return h;
    endfunction

    function int unsigned probe(bit [63:0] k, bit [3:0] n, bit [31:0] h,
                                output bit hit, output bit ok);
      int unsigned base, s, tomb;
      bit [31:0] i, p, msk;
      bit have_tomb;
      base = bank * TABLE_DEPTH;
      msk = size - 1;
      i = h;
      p = h;
      tomb = 0;
      have_tomb = 0;
      hit = 0;
      ok = 1;
      s = base + (i & msk);
      if (slot_mark[s] == MARK_EMPTY) return s;
      if (slot_mark[s] == MARK_LIVE && slot_len[s] == n && slot_hash[s] == h &&
          slot_key[s] == k) begin
        hit = 1;
        return s;
      end
      if (slot_mark[s] == MARK_TOMB) begin
        have_tomb = 1;
        tomb = s;
      end
      for (int unsigned c = 0; c < 2 * size + 16; c++) begin
        i = i * 5 + p + 1;
        s = base + (i & msk);
        if (slot_mark[s] == MARK_EMPTY) return have_tomb ? tomb : s;
        if (slot_mark[s] == MARK_LIVE && slot_len[s] == n && slot_hash[s] == h &&
            slot_key[s] == k) begin
          hit = 1;
          return s;
        end
        if (slot_mark[s] == MARK_TOMB && !have_tomb) begin
          have_tomb = 1;
          tomb = s;
        end
        p = p >> 5;
      end
      if (!have_tomb) ok = 0;
      return tomb;
    endfunction

    function void grow();
      int unsigned minsize, newsize, nbase, obase, count, s, t, c;
      bit [31:0] i, p, nmask, h;
      minsize = (live > BIG_TABLE ? 2 : 4) * size;
      newsize = 8;
      while (newsize <= minsize && newsize < TABLE_DEPTH) newsize = newsize << 1;
      if (newsize <= size) return;
      nbase = (bank ^ 1) * TABLE_DEPTH;
      obase = bank * TABLE_DEPTH;
      nmask = newsize - 1;
      count = 0;
      for (int unsigned j = 0; j < newsize; j++) slot_mark[nbase + j] = MARK_EMPTY;
      for (int unsigned j = 0; j < size; j++) begin
        s = obase + j;
        if (slot_mark[s] == MARK_LIVE) begin
          h = slot_hash[s];
          i = h;
          p = h;
          c = 0;
          t = nbase + (i & nmask);
          while (slot_mark[t] != MARK_EMPTY && c < 2 * newsize + 16) begin
            i = i * 5 + p + 1;
            p = p >> 5;
            t = nbase + (i & nmask);
            c++;
          end
          if (slot_mark[t] == MARK_EMPTY) begin
            slot_key[t]  = slot_key[s];
            slot_len[t]  = slot_len[s];
            slot_hash[t] = h;
            slot_val[t]  = slot_val[s];
            slot_mark[t] = MARK_LIVE;
            count++;
          end
        end
      end
      bank = bank ^ 1;
      size = newsize;
      live = count;
      filled = count;
    endfunction

    // One accepted item: update the mirrored table, queue the answer.
    function void note_item(logic [2:0] op, logic [63:0] key, logic [3:0] len_in,
                            logic [VALUE_BITS-1:0] val, logic [VALUE_BITS-1:0] dflt);
      map_answer_t a;
      bit [3:0] n;
      bit [63:0] k;
      bit [31:0] h;
      bit hit, ok;
      int unsigned s;
      a.status = ST_OK;
      a.found = 0;
      a.value = '0;
      if (op == OP_CLEAR) begin
        for (int unsigned j = 0; j < size; j++) slot_mark[bank * TABLE_DEPTH + j] = MARK_EMPTY;
        live = 0;
        filled = 0;
      end else if (op <= OP_HAS) begin
        n = len_in;
        if (n < 1) n = 4'd1;
        if (n > KEY_BYTES) n = 4'(KEY_BYTES);
        k = key;
        if (n < 8) k = k & ((64'd1 << (8 * n)) - 1);
        h = bkdr(k, n);
        s = probe(k, n, h, hit, ok);
        a.found = hit;
        if (op == OP_GET) begin
          a.status = hit ? ST_OK : ST_MISS;
          a.value = hit ? slot_val[s] : dflt;
        end else if (op == OP_REMOVE || op == OP_HAS) begin
          a.status = hit ? ST_OK : ST_MISS;
          if (hit && op == OP_REMOVE) begin
            slot_mark[s] = MARK_TOMB;
            live--;
          end
        end else if (hit) begin
          if (op == OP_SET) slot_val[s] = val;
        end else if (!ok) begin
          a.status = ST_FULL;
        end else if (slot_mark[s] == MARK_EMPTY && filled + 1 >= size) begin
          a.status = ST_FULL;
        end else begin
          if (slot_mark[s] == MARK_EMPTY) filled++;
          slot_key[s]  = k;
          slot_len[s]  = n;
          slot_hash[s] = h;
          slot_val[s]  = val;
          slot_mark[s] = MARK_LIVE;
          live++;
          if (filled * 3 >= size * 2) grow();
        end
      end
      answers.push_back(a);
    endfunction

    function void report_mismatch(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endfunction

    function void check_result(logic [1:0] st, logic fnd, logic [VALUE_BITS-1:0] rv);
      map_answer_t a;
      if (answers.size() == 0) begin
        report_mismatch("result with no item outstanding");
        return;
      end
      a = answers.pop_front();
      if (st !== a.status)
        report_mismatch($sformatf("status %0d, expected %0d", st, a.status));
      if (fnd !== a.found)
        report_mismatch($sformatf("found %0d, expected %0d", fnd, a.found));
      if (rv !== a.value)
        report_mismatch($sformatf("result_value %h, expected %h", rv, a.value));
    endfunction
  endclass

  logic                  clk = 0;
  logic                  rst_n = 0;
  logic                  start = 0;
  logic                  busy;
  logic [2:0]            in_op = OP_GET;
  logic [63:0]           in_key = '0;
  logic [3:0]            in_key_len = 4'd1;
  logic [VALUE_BITS-1:0] in_value = '0;
  logic [VALUE_BITS-1:0] in_default_value = '0;
  logic                  out_valid;
  logic [1:0]            out_status;
  logic                  out_found;
  logic [VALUE_BITS-1:0] out_result_value;

  hash_scoreboard sb = new();
  int idle_cycles = 0;
  bit no_gaps = 0;
  bit [63:0] pool_key [POOL_MAX];
  bit [3:0]  pool_len [POOL_MAX];

  always #6 clk = ~clk;

  open_addressing_hash_map_top u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_key(in_key), .in_key_len(in_key_len),
    .in_value(in_value), .in_default_value(in_default_value),
    .out_valid(out_valid), .out_status(out_status), .out_found(out_found),
    .out_result_value(out_result_value)
  );

  // Monitor: note accepted items, check results, watch for a hang.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        sb.note_item(in_op, in_key, in_key_len, in_value, in_default_value);
        idle_cycles = 0;
      end else if (out_valid) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (out_valid) sb.check_result(out_status, out_found, out_result_value);
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Drive one item from a falling edge and hold it until accepted.
  task automatic send_item(logic [2:0] op, logic [63:0] key, logic [3:0] len,
                           logic [VALUE_BITS-1:0] val, logic [VALUE_BITS-1:0] dflt);
    int gap;
    if (!no_gaps && $urandom_range(0, 99) < 23) begin
      gap = $urandom_range(1, 5);
      start = 0;
      repeat (gap) @(negedge clk);
    end
    start = 1;
    in_op = op;
    in_key = key;
    in_key_len = len;
    in_value = val;
    in_default_value = dflt;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [2:0] pick_op();
    int r;
    r = $urandom_range(0, 999);
    if (r < 200) return OP_GET;
    if (r < 450) return OP_SET;
    if (r < 650) return OP_ADD;
    if (r < 800) return OP_REMOVE;
    if (r < 985) return OP_HAS;
    if (r < 990) return OP_CLEAR;
    return r[0] ? OP_RSVD_A : OP_RSVD_B;
  endfunction

  initial begin
    int pool_n, idx;
    logic [63:0] k, junk;
    logic [3:0] n;
    foreach (pool_key[j]) begin
      pool_key[j] = {$urandom, $urandom};
      pool_len[j] = 4'($urandom_range(1, 8));
    end
    repeat (3) @(negedge clk);
    rst_n = 1;

    // Directed: empty table, hits, misses, length clamps, extremes.
    send_item(OP_GET,    64'h41, 4'd1, '0, 32'hFFFF_FFFF);
    send_item(OP_HAS,    64'h41, 4'd1, '0, '0);
    send_item(OP_REMOVE, 64'h41, 4'd1, '0, '0);
    send_item(OP_SET,    64'h41, 4'd1, 32'hFFFF_FFFF, '0);
    send_item(OP_GET,    64'h41, 4'd1, '0, 32'h1234_5678);
    send_item(OP_SET,    64'h41, 4'd1, 32'h0, '0);
    send_item(OP_ADD,    64'h41, 4'd1, 32'h5555_AAAA, '0);
    send_item(OP_GET,    64'hFF41, 4'd0, '0, '0);        // length zero acts as one
    send_item(OP_ADD,    '1, 4'd8, 32'hA5A5_5A5A, '0);
    send_item(OP_GET,    '1, 4'd15, '0, '0);             // length clamps to eight
    send_item(OP_HAS,    '1, 4'd9, '0, '0);
    send_item(OP_SET,    64'h0, 4'd8, 32'h1, '0);
    send_item(OP_GET,    64'h0, 4'd7, '0, 32'h77);        // shorter key, distinct
    send_item(OP_REMOVE, 64'h0, 4'd8, '0, '0);
    send_item(OP_REMOVE, 64'h0, 4'd8, '0, '0);
    send_item(OP_ADD,    64'h0, 4'd8, 32'h2, '0);         // reuses the tombstone
    send_item(OP_RSVD_A, 64'h41, 4'd1, 32'h9, 32'h9);
    send_item(OP_RSVD_B, '1, 4'd8, '1, '1);
    send_item(OP_SET,    64'h4241, 4'd2, 32'h3, '0);
    send_item(OP_SET,    64'h434241, 4'd3, 32'h4, '0);
    send_item(OP_SET,    64'h44434241, 4'd4, 32'h5, '0);  // sixth fill grows the table
    send_item(OP_GET,    64'h4241, 4'd2, '0, '0);
    send_item(OP_CLEAR,  '1, 4'd8, '1, '1);
    send_item(OP_GET,    '1, 4'd8, '0, 32'hDEAD_BEEF);

    // Random: key pool widens over time so the table grows through its sizes.
    for (int it = 0; it < N_RANDOM; it++) begin
      no_gaps = (it >= 600 && it < 800);
      pool_n = 12 + it / 2;
      if (pool_n > POOL_MAX) pool_n = POOL_MAX;
      idx = $urandom_range(0, pool_n - 1);
      k = pool_key[idx];
      n = pool_len[idx];
      if (n < 8) k = k & ((64'd1 << (8 * n)) - 1);
      if ($urandom_range(0, 9) == 0) begin
        junk = {$urandom, $urandom};
        if (n < 8) k = k | (junk & ~((64'd1 << (8 * n)) - 1));
      end
      if ($urandom_range(0, 19) == 0) begin
        k = {$urandom, $urandom};
        n = 4'($urandom_range(0, 15));
      end
      send_item(pick_op(), k, n, $urandom, $urandom);
    end
    start = 0;

    while (sb.answers.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
